// ===== design/stp_pkg.sv =====
package stp_pkg;

    localparam int RANGE_W  = 13;
    localparam int OFFSET_W = 10;
    localparam int RAY_W    = 8;
    localparam int IN_W     = 16;
    localparam int X_W      = 15;
    localparam int Y_W      = 14;
    localparam int COEF_W   = 15;
    localparam int PROD_W   = RANGE_W + COEF_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [RANGE_W-1:0]         MAX_RANGE_RESET   = 13'd4000;
    localparam logic [RANGE_W-1:0]         MIN_RANGE_RESET   = 13'd50;
    localparam logic signed [OFFSET_W-1:0] MOUNT_OFFSET_RESET = 10'sd20;
    localparam logic [RANGE_W-1:0]         CENTRE_STOP_RESET = 13'd350;
    localparam logic [RANGE_W-1:0]         SIDE_STOP_RESET   = 13'd100;

    // half a millimetre in q15, for round to nearest
    localparam logic [PROD_W-1:0] ROUND_HALF = 28'd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_RANGE    = 3'd0,
        CFG_MIN_RANGE    = 3'd1,
        CFG_MOUNT_OFFSET = 3'd2,
        CFG_CENTRE_STOP  = 3'd3,
        CFG_SIDE_STOP    = 3'd4
    } stp_cfg_index_t;

    typedef struct packed {
        logic [RANGE_W-1:0]         max_range;
        logic [RANGE_W-1:0]         min_range;
        logic signed [OFFSET_W-1:0] mount_offset;
        logic [RANGE_W-1:0]         centre_stop;
        logic [RANGE_W-1:0]         side_stop;
    } stp_cfg_t;

    // classified ray handed from the front to the back
    typedef struct packed {
        logic [RANGE_W-1:0] range;
        logic [RAY_W-1:0]   ray;
        logic               valid;
        logic               emergency;
        logic               last;
    } stp_item_t;

    // round(32768*sin(k deg)) for k = 0..90, saturated to 32767
    localparam logic [COEF_W-1:0] QUARTER_SINE [0:90] = '{
        15'd0,     15'd572,   15'd1144,  15'd1715,  15'd2286,
        15'd2856,  15'd3425,  15'd3993,  15'd4560,  15'd5126,
        15'd5690,  15'd6252,  15'd6813,  15'd7371,  15'd7927,
        15'd8481,  15'd9032,  15'd9580,  15'd10126, 15'd10668,
        15'd11207, 15'd11743, 15'd12275, 15'd12803, 15'd13328,
        15'd13848, 15'd14365, 15'd14876, 15'd15384, 15'd15886,
        15'd16384, 15'd16877, 15'd17364, 15'd17847, 15'd18324,
        15'd18795, 15'd19261, 15'd19720, 15'd20174, 15'd20622,
        15'd21063, 15'd21498, 15'd21926, 15'd22348, 15'd22763,
        15'd23170, 15'd23571, 15'd23965, 15'd24351, 15'd24730,
        15'd25102, 15'd25466, 15'd25822, 15'd26170, 15'd26510,
        15'd26842, 15'd27166, 15'd27482, 15'd27789, 15'd28088,
        15'd28378, 15'd28660, 15'd28932, 15'd29197, 15'd29452,
        15'd29698, 15'd29935, 15'd30163, 15'd30382, 15'd30592,
        15'd30792, 15'd30983, 15'd31164, 15'd31336, 15'd31499,
        15'd31651, 15'd31795, 15'd31928, 15'd32052, 15'd32166,
        15'd32270, 15'd32365, 15'd32449, 15'd32524, 15'd32588,
        15'd32643, 15'd32688, 15'd32723, 15'd32748, 15'd32763,
        15'd32767
    };

endpackage

// ===== design/stp_fifo.sv =====
module stp_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  stp_pkg::stp_item_t  push_item,
    output logic                pop_valid,
    input  logic                pop_ready,
    output stp_pkg::stp_item_t  pop_item
);

    localparam int DEPTH = stp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    stp_pkg::stp_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/stp_front.sv =====
module stp_front
#(
    parameter int RAY_COUNT = 181,
    parameter int SIDE_RAYS = 45
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  stp_pkg::stp_cfg_t             cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [stp_pkg::IN_W-1:0]      range_mm,
    output logic                          push_valid,
    input  logic                          push_ready,
    output stp_pkg::stp_item_t            push_item
);

    localparam int RW = stp_pkg::RANGE_W;
    localparam int MW = RW + 9;

    logic [stp_pkg::RAY_W-1:0] ray_reg, ray_next;
    logic                      latch_reg, latch_next;
    logic                      accept;
    logic [RW-1:0]             r_clamp;
    logic                      side_sector;
    logic [9:0]                two_i;
    logic [9:0]                centre_dist;
    logic [8:0]                weight;
    logic [MW-1:0]             lhs;
    logic [MW-1:0]             rhs;
    logic                      hit;
    logic                      latched_now;
    logic                      last;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    always_comb
    begin
        r_clamp = (range_mm > {{(stp_pkg::IN_W-RW){1'b0}}, cfg.max_range})
                  ? cfg.max_range : range_mm[RW-1:0];

        side_sector = ({2'b00, ray_reg} <= 10'(SIDE_RAYS))
                   || ({2'b00, ray_reg} + 10'(SIDE_RAYS) >= 10'(RAY_COUNT - 1));

        // triangle weight RAY_COUNT - |2i - RAY_COUNT|
        two_i       = {1'b0, ray_reg, 1'b0};
        centre_dist = (two_i >= 10'(RAY_COUNT)) ? two_i - 10'(RAY_COUNT)
                                                : 10'(RAY_COUNT) - two_i;
        weight      = 9'(10'(RAY_COUNT) - centre_dist);

        lhs = MW'(r_clamp) * MW'(RAY_COUNT);
        rhs = MW'(cfg.centre_stop) * MW'(weight);
        hit = side_sector ? (r_clamp < cfg.side_stop) : (lhs < rhs);

        latched_now = latch_reg || hit;
        last        = (ray_reg == stp_pkg::RAY_W'(RAY_COUNT - 1));

        push_item.range     = r_clamp;
        push_item.ray       = ray_reg;
        push_item.valid     = (r_clamp > cfg.min_range) && !latched_now;
        push_item.emergency = latched_now;
        push_item.last      = last;

        ray_next   = ray_reg;
        latch_next = latch_reg;
        if (accept)
        begin
            ray_next   = last ? '0 : ray_reg + 1'b1;
            latch_next = last ? 1'b0 : latched_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_reg   <= '0;
            latch_reg <= 1'b0;
        end
        else
        begin
            ray_reg   <= ray_next;
            latch_reg <= latch_next;
        end
    end

endmodule

// ===== design/stp_back.sv =====
module stp_back
#(
    parameter int RAY_COUNT = 181
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic signed [stp_pkg::OFFSET_W-1:0]  mount_offset,
    input  logic                                 pop_valid,
    output logic                                 pop_ready,
    input  stp_pkg::stp_item_t                   pop_item,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [stp_pkg::X_W-1:0]       x_mm,
    output logic signed [stp_pkg::Y_W-1:0]       y_mm,
    output logic                                 point_valid,
    output logic                                 emergency,
    output logic [stp_pkg::RAY_W-1:0]            ray_number,
    output logic                                 end_of_scan
);

    localparam int RW   = stp_pkg::RANGE_W;
    localparam int PW   = stp_pkg::PROD_W;
    localparam int CW   = stp_pkg::COEF_W;
    localparam int HALF = RAY_COUNT / 2;

    logic                 adv_out, adv_s1;
    logic [7:0]           ang;
    logic                 ang_neg;
    logic [6:0]           sin_idx, cos_idx;
    logic                 cos_neg;
    logic [CW-1:0]        sin_mag, cos_mag;
    logic [PW-1:0]        prod_x_next, prod_y_next;

    logic                 s1_valid_reg;
    stp_pkg::stp_item_t   s1_item_reg;
    logic [PW-1:0]        s1_prod_x_reg, s1_prod_y_reg;
    logic                 s1_neg_x_reg, s1_neg_y_reg;

    logic [RW-1:0]                  px, py;
    logic signed [stp_pkg::X_W-1:0] x_next;
    logic signed [stp_pkg::Y_W-1:0] y_next;

    logic                           out_valid_reg;
    logic signed [stp_pkg::X_W-1:0] x_reg;
    logic signed [stp_pkg::Y_W-1:0] y_reg;
    logic                           pv_reg, em_reg, last_reg;
    logic [stp_pkg::RAY_W-1:0]      ray_reg;

    assign adv_out   = !out_valid_reg || out_ready;
    assign adv_s1    = !s1_valid_reg || adv_out;
    assign pop_ready = adv_s1;

    // angle of the ray from the centre, then quarter-wave table lookup
    always_comb
    begin
        ang_neg = (pop_item.ray < 8'(HALF));
        ang     = ang_neg ? 8'(HALF) - pop_item.ray : pop_item.ray - 8'(HALF);
        sin_idx = (ang <= 8'd90) ? ang[6:0] : 7'(8'd180 - ang);
        cos_neg = (ang > 8'd90);
        cos_idx = cos_neg ? 7'(ang - 8'd90) : 7'(8'd90 - ang);
        sin_mag = stp_pkg::QUARTER_SINE[sin_idx];
        cos_mag = stp_pkg::QUARTER_SINE[cos_idx];
        prod_x_next = PW'(pop_item.range) * PW'(cos_mag) + stp_pkg::ROUND_HALF;
        prod_y_next = PW'(pop_item.range) * PW'(sin_mag) + stp_pkg::ROUND_HALF;
    end

    always_comb
    begin
        px = s1_prod_x_reg[PW-1:PW-RW];
        py = s1_prod_y_reg[PW-1:PW-RW];
        x_next = s1_neg_x_reg ? -$signed({2'b00, px}) : $signed({2'b00, px});
        x_next = x_next + stp_pkg::X_W'(mount_offset);
        y_next = s1_neg_y_reg ? -$signed({1'b0, py}) : $signed({1'b0, py});
        if (!s1_item_reg.valid)
        begin
            x_next = '0;
            y_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_s1)
            begin
                s1_valid_reg <= pop_valid;
            end
            if (adv_out)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_s1 && pop_valid)
        begin
            s1_item_reg   <= pop_item;
            s1_prod_x_reg <= prod_x_next;
            s1_prod_y_reg <= prod_y_next;
            s1_neg_x_reg  <= cos_neg;
            s1_neg_y_reg  <= ang_neg;
        end
        if (adv_out && s1_valid_reg)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            pv_reg   <= s1_item_reg.valid;
            em_reg   <= s1_item_reg.emergency;
            ray_reg  <= s1_item_reg.ray;
            last_reg <= s1_item_reg.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign x_mm        = x_reg;
    assign y_mm        = y_reg;
    assign point_valid = pv_reg;
    assign emergency   = em_reg;
    assign ray_number  = ray_reg;
    assign end_of_scan = last_reg;

endmodule

// ===== design/scan_to_points_emergency_stop_unit.sv =====
// path: an accepted item is written into the queue, registered in the multiply stage and
// then in the output register, which offers it and holds it while the output side stalls
// throughput: one item per cycle while the output side is ready; the combinational classifier
// in the front and the two-stage multiply and round pipeline in the back both take an item every cycle
// reset: rst_n clears the ray counter, the stop latch, the queue and the pipeline at once
// and loads the register defaults; no clearing pass
module scan_to_points_emergency_stop_unit
#(
    parameter int RAY_COUNT = 181,
    parameter int SIDE_RAYS = 45
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [stp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [stp_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [stp_pkg::IN_W-1:0]              range_mm,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [stp_pkg::X_W-1:0]        x_mm,
    output logic signed [stp_pkg::Y_W-1:0]        y_mm,
    output logic                                  point_valid,
    output logic                                  emergency,
    output logic [stp_pkg::RAY_W-1:0]             ray_number,
    output logic                                  end_of_scan
);

    stp_pkg::stp_cfg_t  cfg_reg;
    logic               q_push_valid, q_push_ready;
    stp_pkg::stp_item_t q_push_item;
    logic               q_pop_valid, q_pop_ready;
    stp_pkg::stp_item_t q_pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_range    <= stp_pkg::MAX_RANGE_RESET;
            cfg_reg.min_range    <= stp_pkg::MIN_RANGE_RESET;
            cfg_reg.mount_offset <= stp_pkg::MOUNT_OFFSET_RESET;
            cfg_reg.centre_stop  <= stp_pkg::CENTRE_STOP_RESET;
            cfg_reg.side_stop    <= stp_pkg::SIDE_STOP_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                stp_pkg::CFG_MAX_RANGE:    cfg_reg.max_range    <= cfg_data;
                stp_pkg::CFG_MIN_RANGE:    cfg_reg.min_range    <= cfg_data;
                stp_pkg::CFG_MOUNT_OFFSET:
                    cfg_reg.mount_offset <= $signed(cfg_data[stp_pkg::OFFSET_W-1:0]);
                stp_pkg::CFG_CENTRE_STOP:  cfg_reg.centre_stop  <= cfg_data;
                stp_pkg::CFG_SIDE_STOP:    cfg_reg.side_stop    <= cfg_data;
                default: ;
            endcase
        end
    end

    stp_front #(
        .RAY_COUNT (RAY_COUNT),
        .SIDE_RAYS (SIDE_RAYS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .range_mm   (range_mm),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item)
    );

    stp_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_item   (q_pop_item)
    );

    stp_back #(
        .RAY_COUNT (RAY_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .mount_offset (cfg_reg.mount_offset),
        .pop_valid    (q_pop_valid),
        .pop_ready    (q_pop_ready),
        .pop_item     (q_pop_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .x_mm         (x_mm),
        .y_mm         (y_mm),
        .point_valid  (point_valid),
        .emergency    (emergency),
        .ray_number   (ray_number),
        .end_of_scan  (end_of_scan)
    );

endmodule

// ===== design/stp_checker.sv =====
module stp_checker
#(
    parameter int RAY_COUNT = 181
)
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic signed [stp_pkg::X_W-1:0]        x_mm,
    input logic signed [stp_pkg::Y_W-1:0]        y_mm,
    input logic                                  point_valid,
    input logic                                  emergency,
    input logic [stp_pkg::RAY_W-1:0]             ray_number,
    input logic                                  end_of_scan
);

    // a stalled item stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ray_number) && $stable(x_mm))
        else $error("stalled item dropped or changed");

    // a latched stop never goes with a usable point
    a_no_point_in_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(point_valid && emergency))
        else $error("point valid while emergency");

    // invalid points carry zero coordinates
    a_zero_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !point_valid |-> (x_mm == '0) && (y_mm == '0))
        else $error("invalid point with nonzero coordinates");

    // end of scan marks exactly the last ray
    a_last_ray: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (end_of_scan == (ray_number == stp_pkg::RAY_W'(RAY_COUNT - 1))))
        else $error("end of scan on the wrong ray");

endmodule

bind scan_to_points_emergency_stop_unit stp_checker #(
    .RAY_COUNT (RAY_COUNT)
) u_stp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .x_mm        (x_mm),
    .y_mm        (y_mm),
    .point_valid (point_valid),
    .emergency   (emergency),
    .ray_number  (ray_number),
    .end_of_scan (end_of_scan)
);

// ===== bench/scan_to_points_emergency_stop_unit_tb.sv =====
`timescale 1ns / 100ps

module scan_to_points_emergency_stop_unit_tb;

    localparam int RAY_COUNT = 181;
    localparam int SIDE_RAYS = 45;
    localparam int PHASES    = 8;
    localparam int PHASE_RAYS = 155;

    typedef struct packed {
        logic signed [stp_pkg::X_W-1:0] x;
        logic signed [stp_pkg::Y_W-1:0] y;
        logic                           point_valid;
        logic                           emergency;
        logic [stp_pkg::RAY_W-1:0]      ray;
        logic                           last;
    } scan_point_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_write_en = 1'b0;
    logic [stp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [stp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [stp_pkg::IN_W-1:0]       range_mm = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic signed [stp_pkg::X_W-1:0] x_mm;
    logic signed [stp_pkg::Y_W-1:0] y_mm;
    logic                           point_valid;
    logic                           emergency;
    logic [stp_pkg::RAY_W-1:0]      ray_number;
    logic                           end_of_scan;

    // scanner model: configuration, ray counter, stop latch, q15 tables
    int max_range;
    int min_range;
    int mount_offset;
    int centre_stop;
    int side_stop;
    int next_ray;
    bit stop_seen;
    int cos_q15 [RAY_COUNT];
    int sin_q15 [RAY_COUNT];

    logic [stp_pkg::IN_W-1:0] ranges_to_send [$];
    scan_point_t              points_due [$];
    scan_point_t              due;

    int  send_gap;
    int  stall_left;
    int  hold_left;
    bit  no_idle;
    int  gen_ray;
    bit  clean_scan;
    int  mismatches;
    int  rays_sent;
    int  points_checked;
    int  valid_points;
    int  stopped_scans;
    int  full_scans;

    scan_to_points_emergency_stop_unit
    #(
        .RAY_COUNT(RAY_COUNT),
        .SIDE_RAYS(SIDE_RAYS)
    )
    i_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .range_mm(range_mm),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .x_mm(x_mm),
        .y_mm(y_mm),
        .point_valid(point_valid),
        .emergency(emergency),
        .ray_number(ray_number),
        .end_of_scan(end_of_scan)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // range times q15 coefficient, rounded half away from zero
    function automatic int scale_q15(int r, int coef);
        int mag;
        int p;
        mag = coef < 0 ? -coef : coef;
        p = (r * mag + 16384) >>> 15;
        return coef < 0 ? -p : p;
    endfunction

    function automatic scan_point_t project_ray(logic [stp_pkg::IN_W-1:0] raw);
        scan_point_t p;
        int ray;
        int r;
        int d;
        int w;
        int x;
        int y;
        bit hit;
        ray = next_ray;
        r = int'(raw) > max_range ? max_range : int'(raw);
        if (ray <= SIDE_RAYS || ray + SIDE_RAYS >= RAY_COUNT - 1)
        begin
            hit = r < side_stop;
        end
        else
        begin
            // centre limit tapers linearly to the sector edges
            d = 2 * ray - RAY_COUNT;
            w = RAY_COUNT - (d < 0 ? -d : d);
            hit = r * RAY_COUNT < centre_stop * w;
        end
        if (hit)
        begin
            stop_seen = 1'b1;
        end
        p.point_valid = (r > min_range) && !stop_seen;
        x = 0;
        y = 0;
        if (p.point_valid)
        begin
            x = scale_q15(r, cos_q15[ray]) + mount_offset;
            y = scale_q15(r, sin_q15[ray]);
        end
        p.x = x[stp_pkg::X_W-1:0];
        p.y = y[stp_pkg::Y_W-1:0];
        p.emergency = stop_seen;
        p.ray = ray[stp_pkg::RAY_W-1:0];
        p.last = (ray == RAY_COUNT - 1);
        if (p.last)
        begin
            next_ray = 0;
            stop_seen = 1'b0;
        end
        else
        begin
            next_ray = ray + 1;
        end
        return p;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (no_idle || sel < 60)
        begin
            return 0;
        end
        if (sel < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (sel < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [stp_pkg::IN_W-1:0] pick_range();
        int sel;
        int stop_mm;
        int floor_mm;
        sel = $urandom_range(0, 99);
        stop_mm = centre_stop > side_stop ? centre_stop : side_stop;
        if (sel < 4)
        begin
            return stp_pkg::IN_W'($urandom);
        end
        if (clean_scan)
        begin
            // picks ranges above every stop limit and the minimum range, before clamping to max_range
            floor_mm = (stop_mm > min_range ? stop_mm : min_range) + 1;
            return stp_pkg::IN_W'($urandom_range(floor_mm, max_range + 200));
        end
        if (sel < 20)
        begin
            return stp_pkg::IN_W'($urandom_range(min_range > 3 ? min_range - 3 : 0,
                                                 min_range + 3));
        end
        if (sel < 35)
        begin
            return stp_pkg::IN_W'($urandom_range(0, stop_mm + 20));
        end
        return stp_pkg::IN_W'($urandom_range(0, max_range + 300));
    endfunction

    task automatic queue_range(logic [stp_pkg::IN_W-1:0] value);
        ranges_to_send.push_back(value);
        gen_ray = (gen_ray + 1) % RAY_COUNT;
    endtask

    task automatic write_reg(stp_pkg::stp_cfg_index_t idx, int value);
        logic [stp_pkg::OFFSET_W-1:0] offset_bits;
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[stp_pkg::CFG_DATA_W-1:0];
        offset_bits = value[stp_pkg::OFFSET_W-1:0];
        case (idx)
            stp_pkg::CFG_MAX_RANGE:    max_range = value & 32'h1FFF;
            stp_pkg::CFG_MIN_RANGE:    min_range = value & 32'h1FFF;
            stp_pkg::CFG_MOUNT_OFFSET: mount_offset = int'($signed(offset_bits));
            stp_pkg::CFG_CENTRE_STOP:  centre_stop = value & 32'h1FFF;
            stp_pkg::CFG_SIDE_STOP:    side_stop = value & 32'h1FFF;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic configure(int max_mm, int min_mm, int offset_mm, int centre_mm,
                             int side_mm);
        write_reg(stp_pkg::CFG_MAX_RANGE, max_mm);
        write_reg(stp_pkg::CFG_MIN_RANGE, min_mm);
        write_reg(stp_pkg::CFG_MOUNT_OFFSET, offset_mm);
        write_reg(stp_pkg::CFG_CENTRE_STOP, centre_mm);
        write_reg(stp_pkg::CFG_SIDE_STOP, side_mm);
        end_writes();
    endtask

    task automatic wait_idle();
        while (ranges_to_send.size() != 0 || in_valid || points_due.size() != 0)
        begin
            @(negedge clk);
        end
        // a little extra margin after the last point
        repeat (4) @(posedge clk);
    endtask

    task automatic check_field(string what, int want, int seen);
        if (want != seen)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want, seen);
            mismatches++;
        end
    endtask

    // sender: one item per handshake, random gaps between items
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                points_due.push_back(project_ray(range_mm));
                rays_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (ranges_to_send.size() > 0)
                begin
                    range_mm <= ranges_to_send.pop_front();
                    in_valid <= 1'b1;
                    send_gap = pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each point, stalls at random, holds off long every 500 points from the 250th
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (points_due.size() == 0)
                begin
                    $display("%0t: point for ray %0d with nothing expected", $time, ray_number);
                    mismatches++;
                end
                else
                begin
                    due = points_due.pop_front();
                    check_field("x_mm", due.x, x_mm);
                    check_field("y_mm", due.y, y_mm);
                    check_field("point_valid", due.point_valid, point_valid);
                    check_field("emergency", due.emergency, emergency);
                    check_field("ray_number", due.ray, ray_number);
                    check_field("end_of_scan", due.last, end_of_scan);
                end
                points_checked++;
                valid_points += point_valid;
                if (end_of_scan)
                begin
                    full_scans++;
                    stopped_scans += emergency;
                end
                if (points_checked % 500 == 250)
                begin
                    hold_left = 120;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    initial
    begin
        int a;
        int m;
        int offset_draw;
        for (int i = 0; i < RAY_COUNT; i++)
        begin
            a = i - RAY_COUNT / 2;
            m = a < 0 ? -a : a;
            cos_q15[i] = m <= 90 ? int'(stp_pkg::QUARTER_SINE[90 - m])
                                 : -int'(stp_pkg::QUARTER_SINE[m - 90]);
            sin_q15[i] = m <= 90 ? int'(stp_pkg::QUARTER_SINE[m])
                                 : int'(stp_pkg::QUARTER_SINE[180 - m]);
            if (a < 0)
            begin
                sin_q15[i] = -sin_q15[i];
            end
        end
        max_range = stp_pkg::MAX_RANGE_RESET;
        min_range = stp_pkg::MIN_RANGE_RESET;
        mount_offset = stp_pkg::MOUNT_OFFSET_RESET;
        centre_stop = stp_pkg::CENTRE_STOP_RESET;
        side_stop = stp_pkg::SIDE_STOP_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // no side stop: clamping, rounding and invalid points without the latch
        write_reg(stp_pkg::CFG_SIDE_STOP, 0);
        end_writes();
        queue_range(16'hFFFF);
        queue_range(16'hAAAA);
        queue_range(16'h5555);
        queue_range(16'd4000);
        queue_range(16'd4001);
        queue_range(16'd3999);
        queue_range(16'd51);
        queue_range(16'd50);
        queue_range(16'd0);
        queue_range(16'd1);
        wait_idle();

        // latch in the side sector, later rays of the scan go invalid
        write_reg(stp_pkg::CFG_SIDE_STOP, stp_pkg::SIDE_STOP_RESET);
        end_writes();
        queue_range(16'd99);
        queue_range(16'd5000);
        queue_range(16'd200);
        queue_range(16'd0);
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            offset_draw = $urandom_range(0, 1023);
            case (p)
                0: configure(4000, 50, 20, 350, 100);
                1: configure(8191, 0, 511, 8191, 0);
                2: configure(0, 0, -512, 0, 0);
                3: configure(8000, 8000, -500, 0, 8000);
                default: configure($urandom_range(200, 8191), $urandom_range(0, 400),
                                   offset_draw >= 512 ? offset_draw - 1024 : offset_draw,
                                   $urandom_range(0, 3000), $urandom_range(0, 1000));
            endcase
            no_idle = (p == 4 || p == 6);
            for (int n = 0; n < PHASE_RAYS; n++)
            begin
                if (gen_ray == 0)
                begin
                    clean_scan = $urandom_range(0, 9) < 6;
                end
                queue_range(pick_range());
            end
            wait_idle();
        end

        repeat (10) @(posedge clk);
        $display("run covered %0d rays in %0d full scans over %0d register settings",
                 rays_sent, full_scans, PHASES + 2);
        $display("%0d scans ended in a stop, %0d points were valid", stopped_scans,
                 valid_points);
        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    initial
    begin
        #400000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/stp_pkg.sv
design/stp_fifo.sv
design/stp_front.sv
design/stp_back.sv
design/scan_to_points_emergency_stop_unit.sv
design/stp_checker.sv
bench/scan_to_points_emergency_stop_unit_tb.sv
